@@ sv/qskf_pkg.sv @@
// ----------------------------------------------------------------------------
// qskf_pkg
// Shared types, constants and tables for the quadrature speed Kalman filter.
// ----------------------------------------------------------------------------
package qskf_pkg;

  localparam int unsigned QSKF_SPEED_FRAC_BITS = 16;

  localparam int unsigned DIV_W  = 48;  // dividend / quotient width
  localparam int unsigned DIVR_W = 33;  // divisor width
  localparam int unsigned MUL_W  = 34;  // multiplier operand width

  localparam logic [30:0] ONE30 = 31'h4000_0000;

  localparam logic [1:0] CFG_TAU    = 2'd0;
  localparam logic [1:0] CFG_RVAR   = 2'd1;
  localparam logic [1:0] CFG_QVAR   = 2'd2;
  localparam logic [1:0] CFG_INVERT = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RAW_GO,
    ST_RAW_WT,
    ST_GAIN_GO,
    ST_GAIN_WT,
    ST_X_GO,
    ST_X_WT,
    ST_HRN_MUL,
    ST_HRN_DIV,
    ST_HRN_UPD,
    ST_EXP_MUL,
    ST_EXP_UPD,
    ST_PRED_MUL,
    ST_PRED_UPD,
    ST_FILT_MUL,
    ST_FILT_UPD,
    ST_VAR_MUL,
    ST_VAR_UPD,
    ST_DONE
  } qskf_state_e;

  // exp(-n) in Q1.16
  function automatic logic [16:0] exp_int(input logic [3:0] n);
    logic [16:0] r;
    begin
      unique case (n)
        4'd0:  r = 17'd65536;
        4'd1:  r = 17'd24109;
        4'd2:  r = 17'd8869;
        4'd3:  r = 17'd3263;
        4'd4:  r = 17'd1200;
        4'd5:  r = 17'd442;
        4'd6:  r = 17'd162;
        4'd7:  r = 17'd60;
        4'd8:  r = 17'd22;
        4'd9:  r = 17'd8;
        4'd10: r = 17'd3;
        4'd11: r = 17'd1;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

  // ceil(2^34 / k), exact floor division for values below 2^30
  function automatic logic [MUL_W-1:0] recip34(input logic [3:0] k);
    logic [MUL_W-1:0] r;
    begin
      unique case (k)
        4'd2:  r = 34'd8589934592;
        4'd3:  r = 34'd5726623062;
        4'd4:  r = 34'd4294967296;
        4'd5:  r = 34'd3435973837;
        4'd6:  r = 34'd2863311531;
        4'd7:  r = 34'd2454267027;
        4'd8:  r = 34'd2147483648;
        4'd9:  r = 34'd1908874354;
        4'd10: r = 34'd1717986919;
        default: r = 34'd0;
      endcase
      return r;
    end
  endfunction

  // quadrature transition: {nonzero, negative}
  function automatic logic [1:0] dir_of(input logic [3:0] idx);
    logic [1:0] r;
    begin
      case (idx)
        4'd1, 4'd7, 4'd13: r = 2'b10;
        4'd2, 4'd11, 4'd14: r = 2'b11;
        default: r = 2'b00;
      endcase
      return r;
    end
  endfunction

endpackage

@@ sv/qskf_div.sv @@
// ----------------------------------------------------------------------------
// qskf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qskf_div
  import qskf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output logic [DIV_W-1:0]  quotient_o,
  output logic              done_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIVR_W:0]   rem_q, rem_d, sh;
  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [DIVR_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d, ge;

  always_comb begin
    sh     = {rem_q[DIVR_W-1:0], dvd_q[DIV_W-1]};
    ge     = sh >= {1'b0, dvs_q};
    rem_d  = ge ? sh - {1'b0, dvs_q} : sh;
    dvd_d  = {dvd_q[DIV_W-2:0], ge};
    cnt_d  = cnt_q - CNT_W'(1);
    busy_d = busy_q && (cnt_q != CNT_W'(1));
    done_d = busy_q && (cnt_q == CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIV_W);
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (busy_q) cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

@@ sv/qskf_mul.sv @@
// ----------------------------------------------------------------------------
// qskf_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module qskf_mul
  import qskf_pkg::*;
(
  input  logic                 clk_i,
  input  logic [MUL_W-1:0]     a_i,
  input  logic [MUL_W-1:0]     b_i,
  output logic [2*MUL_W-1:0]   p_o
);

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ sv/quadrature_speed_kalman_filter.sv @@
// ----------------------------------------------------------------------------
// quadrature_speed_kalman_filter
// Encoder edge to speed estimate through a scalar Kalman filter.
// A request runs three passes of the shared divider, the Horner steps and the
//   multiplier and hand-off steps; the Horner steps are skipped when the decay
//   term saturates. A new request is taken only in idle, once the last result
//   is loaded into the result register, which waits while an earlier result is
//   unread; the first edge on a channel makes no result. Reset is asynchronous,
//   active low, and restores the register defaults and the filter state at once.
// ----------------------------------------------------------------------------
module quadrature_speed_kalman_filter
  import qskf_pkg::*;
#(
  parameter int unsigned SPEED_FRAC_BITS = QSKF_SPEED_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // edge requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        edge_source_i,
  input  logic        pin_a_i,
  input  logic        pin_b_i,
  input  logic [31:0] timestamp_us_i,
  input  logic signed [31:0] target_speed_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] raw_speed_o,
  output logic signed [31:0] predicted_speed_o,
  output logic signed [31:0] filtered_speed_o,
  output logic [15:0] filter_gain_o
);

  // round((2pi/3)*1e6 * 2^F): 2094395102 is the constant in milli units
  localparam logic [DIV_W-1:0] RAW_NUM =
    DIV_W'(((64'd2094395102 << SPEED_FRAC_BITS) + 64'd500) / 64'd1000);

  // configuration
  logic [23:0] tau_q;
  logic [15:0] rvar_q, qvar_q;
  logic        inv_q;

  // filter state
  logic [1:0]  prev_pins_q;
  logic [1:0]  seen_q;
  logic [31:0] last_t_q [2];
  logic [31:0] est_q;
  logic [31:0] var_q;

  // per-request working registers
  qskf_state_e state_q, state_d;
  logic [31:0] wss_q, dt_q;
  logic        dir_nz_q, dir_neg_q;
  logic [31:0] raw_q, pred_q, filt_q;
  logic [15:0] gain_q;
  logic [3:0]  n_q, k_q;
  logic [29:0] f30_q;
  logic [30:0] t_q, alpha_q;

  // result register
  logic        out_valid_q;
  logic [31:0] o_raw_q, o_pred_q, o_filt_q;
  logic [15:0] o_gain_q;

  // shared units
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dvd, div_quo;
  logic [DIVR_W-1:0] div_dvs;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;

  qskf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  qskf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // ---- request decode ----
  logic       in_acc, first_edge;
  logic [1:0] cur_pins, dcode;

  assign in_acc     = in_valid_i && in_ready_o;
  assign cur_pins   = {pin_a_i, pin_b_i};
  assign first_edge = !seen_q[edge_source_i];
  assign dcode      = dir_of({prev_pins_q, cur_pins});

  // ---- signed differences as sign and magnitude ----
  logic [32:0] dw, dr, dw_mag, dr_mag;
  logic        dw_neg, dr_neg;

  always_comb begin
    dw     = {wss_q[31], wss_q} - {est_q[31], est_q};
    dw_neg = dw[32];
    dw_mag = dw_neg ? 33'(-dw) : dw;
    dr     = {raw_q[31], raw_q} - {pred_q[31], pred_q};
    dr_neg = dr[32];
    dr_mag = dr_neg ? 33'(-dr) : dr;
  end

  // ---- divider operand select ----
  logic [32:0] gain_den;
  assign gain_den = {1'b0, var_q} + {1'b0, rvar_q, 16'd0};

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_q)
      ST_RAW_GO: begin
        div_start = 1'b1;
        div_dvd   = RAW_NUM + DIV_W'(dt_q >> 1);
        div_dvs   = DIVR_W'(dt_q);
      end
      ST_GAIN_GO: begin
        div_start = 1'b1;
        div_dvd   = {var_q, 16'd0};
        div_dvs   = gain_den;
      end
      ST_X_GO: begin
        div_start = 1'b1;
        div_dvd   = {dt_q, 16'd0};
        div_dvs   = DIVR_W'(tau_q);
      end
      default: ;
    endcase
  end

  // ---- multiplier operand select ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_HRN_MUL: begin
        mul_a = MUL_W'(f30_q);
        mul_b = MUL_W'(t_q);
      end
      ST_HRN_DIV: begin
        mul_a = MUL_W'(mul_p[59:30]);
        mul_b = recip34(k_q);
      end
      ST_EXP_MUL: begin
        mul_a = MUL_W'(exp_int(n_q));
        mul_b = MUL_W'(t_q);
      end
      ST_PRED_MUL: begin
        mul_a = MUL_W'(dw_mag);
        mul_b = MUL_W'(alpha_q);
      end
      ST_FILT_MUL: begin
        mul_a = MUL_W'(dr_mag);
        mul_b = MUL_W'(gain_q);
      end
      ST_VAR_MUL: begin
        mul_a = MUL_W'(17'h10000 - {1'b0, gain_q});
        mul_b = MUL_W'(var_q);
      end
      default: ;
    endcase
  end

  // ---- step results ----
  logic [31:0] raw_mag;
  logic [15:0] gain_v;
  logic [31:0] e30;
  logic [30:0] alpha_v;
  logic [32:0] pred_r, filt_r;
  logic [33:0] pred_s, filt_s;
  logic [33:0] pn;

  always_comb begin
    // raw speed magnitude, saturating
    if (dt_q == 32'd0 || div_quo[DIV_W-1:31] != '0) raw_mag = 32'h7FFF_FFFF;
    else raw_mag = {1'b0, div_quo[30:0]};
    // gain, saturating
    if (gain_den == 33'd0) gain_v = 16'd0;
    else if (div_quo[DIV_W-1:16] != '0) gain_v = 16'hFFFF;
    else gain_v = div_quo[15:0];
    // exp(-x) and alpha
    e30 = 32'((mul_p[47:0] + 48'd32768) >> 16);
    alpha_v = (e30 > 32'(ONE30)) ? 31'd0 : ONE30 - 31'(e30);
    // prediction and correction, half away from zero
    pred_r = 33'((mul_p[62:0] + 63'(1) * (63'd1 << 29)) >> 30);
    pred_s = dw_neg ? {{2{est_q[31]}}, est_q} - {1'b0, pred_r}
                    : {{2{est_q[31]}}, est_q} + {1'b0, pred_r};
    filt_r = 33'((mul_p[48:0] + 49'd32768) >> 16);
    filt_s = dr_neg ? {{2{pred_q[31]}}, pred_q} - {1'b0, filt_r}
                    : {{2{pred_q[31]}}, pred_q} + {1'b0, filt_r};
    // variance update
    pn = 34'((mul_p[49:0] + 50'd32768) >> 16) + {2'b0, qvar_q, 16'd0};
  end

  // ---- sequencer: next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc && !first_edge) state_d = ST_RAW_GO;
      ST_RAW_GO:   state_d = ST_RAW_WT;
      ST_RAW_WT:   if (div_done) state_d = ST_GAIN_GO;
      ST_GAIN_GO:  state_d = ST_GAIN_WT;
      ST_GAIN_WT:  if (div_done) state_d = ST_X_GO;
      ST_X_GO:     state_d = ST_X_WT;
      ST_X_WT: begin
        if (div_done) begin
          if (tau_q == 24'd0 || div_quo[DIV_W-1:20] != '0) state_d = ST_PRED_MUL;
          else state_d = ST_HRN_MUL;
        end
      end
      ST_HRN_MUL:  state_d = ST_HRN_DIV;
      ST_HRN_DIV:  state_d = (k_q == 4'd1) ? ST_EXP_MUL : ST_HRN_UPD;
      ST_HRN_UPD:  state_d = ST_HRN_MUL;
      ST_EXP_MUL:  state_d = ST_EXP_UPD;
      ST_EXP_UPD:  state_d = ST_PRED_MUL;
      ST_PRED_MUL: state_d = ST_PRED_UPD;
      ST_PRED_UPD: state_d = ST_FILT_MUL;
      ST_FILT_MUL: state_d = ST_FILT_UPD;
      ST_FILT_UPD: state_d = ST_VAR_MUL;
      ST_VAR_MUL:  state_d = ST_VAR_UPD;
      ST_VAR_UPD:  state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---- sequencer: handshake outputs ----
  logic load_out;
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DONE: load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // ---- control and state registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tau_q       <= 24'd200000;
      rvar_q      <= 16'd400;
      qvar_q      <= 16'd50;
      inv_q       <= 1'b0;
      prev_pins_q <= 2'b00;
      seen_q      <= 2'b00;
      last_t_q[0] <= '0;
      last_t_q[1] <= '0;
      est_q       <= '0;
      var_q       <= 32'd2000 << 16;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == {6'd0, CFG_TAU})    tau_q  <= cfg_data_i[23:0];
        if (cfg_index_i == {6'd0, CFG_RVAR})   rvar_q <= cfg_data_i[15:0];
        if (cfg_index_i == {6'd0, CFG_QVAR})   qvar_q <= cfg_data_i[15:0];
        if (cfg_index_i == {6'd0, CFG_INVERT}) inv_q  <= cfg_data_i[0];
      end
      if (in_acc) begin
        prev_pins_q              <= cur_pins;
        seen_q[edge_source_i]    <= 1'b1;
        last_t_q[edge_source_i]  <= timestamp_us_i;
      end
      if (state_q == ST_VAR_UPD) begin
        est_q <= filt_q;
        var_q <= (pn[33:32] != 2'b00) ? 32'hFFFF_FFFF : pn[31:0];
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wss_q     <= target_speed_i;
      dt_q      <= timestamp_us_i - last_t_q[edge_source_i];
      dir_nz_q  <= dcode[1];
      dir_neg_q <= dcode[0] ^ inv_q;
    end
    unique case (state_q)
      ST_RAW_WT: if (div_done) begin
        if (!dir_nz_q) raw_q <= '0;
        else raw_q <= dir_neg_q ? 32'(-raw_mag) : raw_mag;
      end
      ST_GAIN_WT: if (div_done) gain_q <= gain_v;
      ST_X_WT: if (div_done) begin
        alpha_q <= ONE30;
        n_q     <= div_quo[19:16];
        f30_q   <= {div_quo[15:0], 14'd0};
        t_q     <= ONE30;
        k_q     <= 4'd10;
      end
      ST_HRN_DIV: if (k_q == 4'd1) t_q <= ONE30 - 31'(mul_p[59:30]);
      ST_HRN_UPD: begin
        t_q <= ONE30 - 31'(mul_p[63:34]);
        k_q <= k_q - 4'd1;
      end
      ST_EXP_UPD:  alpha_q <= alpha_v;
      ST_PRED_UPD: pred_q  <= pred_s[31:0];
      ST_FILT_UPD: filt_q  <= filt_s[31:0];
      default: ;
    endcase
    if (load_out) begin
      o_raw_q  <= raw_q;
      o_pred_q <= pred_q;
      o_filt_q <= filt_q;
      o_gain_q <= gain_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign raw_speed_o       = o_raw_q;
  assign predicted_speed_o = o_pred_q;
  assign filtered_speed_o  = o_filt_q;
  assign filter_gain_o     = o_gain_q;

endmodule
